[hdl/qptg_pkg.sv]
// Package for the quintic point-to-point trajectory generator.
// Holds the shared types, arithmetic unit codes and fixed constants.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package qptg_pkg;

	localparam int WORD_W = 64;
	localparam int WIDE_W = 128;

	// Acceleration time constant 10/sqrt(3) in Q16.
	localparam logic [WORD_W-1:0] ACC_CONST = 64'd378372;
	localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;

	// Quintic remap p(s) = s^3 * (10 - 15 s + 6 s^2).
	localparam int COEF_A = 10;
	localparam int COEF_B = 15;
	localparam int COEF_C = 6;

	localparam int NUM_REGS = 6;
	localparam logic [2:0] REG_LIN_VEL  = 3'd0;
	localparam logic [2:0] REG_LIN_ACC  = 3'd1;
	localparam logic [2:0] REG_ROT_VEL  = 3'd2;
	localparam logic [2:0] REG_ROT_ACC  = 3'd3;
	localparam logic [2:0] REG_LIN_STEP = 3'd4;
	localparam logic [2:0] REG_ROT_STEP = 3'd5;

	localparam logic OPC_PLAN = 1'b0;
	localparam logic OPC_NEXT = 1'b1;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

`default_nettype wire

[hdl/qptg_if.sv]
// Valid/ready channel interfaces of the trajectory generator.
// One interface for the command channel, one for the via point channel.
// No dependencies.
`default_nettype none

interface qptg_in_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] start_k;
	logic signed [COORD_WIDTH-1:0] goal_x;
	logic signed [COORD_WIDTH-1:0] goal_y;
	logic signed [COORD_WIDTH-1:0] goal_z;
	logic signed [COORD_WIDTH-1:0] goal_k;
	logic [30:0]                   min_time;

	modport source (output valid, opcode, start_x, start_y, start_z, start_k,
		goal_x, goal_y, goal_z, goal_k, min_time, input ready);
	modport sink (input valid, opcode, start_x, start_y, start_z, start_k,
		goal_x, goal_y, goal_z, goal_k, min_time, output ready);
endinterface

interface qptg_out_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic                          ok_flag;
	logic signed [COORD_WIDTH-1:0] via_x;
	logic signed [COORD_WIDTH-1:0] via_y;
	logic signed [COORD_WIDTH-1:0] via_z;
	logic signed [COORD_WIDTH-1:0] via_k;
	logic [30:0]                   via_time;

	modport source (output valid, ok_flag, via_x, via_y, via_z, via_k, via_time,
		input ready);
	modport sink (input valid, ok_flag, via_x, via_y, via_z, via_k, via_time,
		output ready);
endinterface

`default_nettype wire

[hdl/quintic_ptp_trajectory_generator_core.sv]
// Quintic point-to-point trajectory generator, top level; depends on qptg_pkg, qptg_if, qptg_alu.
// A plan transaction uses three squares and a root and then,
// for each nonzero length, three divides, a multiply and a root.
// A next transaction uses eight multiplies, or none when done
// or snapping to the goal. One command at a time goes through the one bit-serial unit.
// Reset is asynchronous: no trajectory planned, limit registers at 1.0.
`default_nettype none

module quintic_ptp_trajectory_generator_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	qptg_in_if.sink      in_ch,
	qptg_out_if.source   out_ch,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import qptg_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int SW  = FRAC_BITS + 2;
	localparam int ASH = 2 * FRAC_BITS - 16;
	localparam logic [WORD_W-1:0] ONE     = 64'd1 << FRAC_BITS;
	localparam logic [WORD_W-1:0] ONE_P1  = ONE + 64'd1;
	localparam logic [WORD_W+1:0] TEN_ONE = 66'(ONE) * 66'(COEF_A);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SQ     = 4'd1;
	localparam logic [3:0] ST_SQRT_L = 4'd2;
	localparam logic [3:0] ST_LEN    = 4'd3;
	localparam logic [3:0] ST_TV     = 4'd4;
	localparam logic [3:0] ST_AM     = 4'd5;
	localparam logic [3:0] ST_AD     = 4'd6;
	localparam logic [3:0] ST_AS     = 4'd7;
	localparam logic [3:0] ST_SD     = 4'd8;
	localparam logic [3:0] ST_PEND   = 4'd9;
	localparam logic [3:0] ST_N2     = 4'd10;
	localparam logic [3:0] ST_N3     = 4'd11;
	localparam logic [3:0] ST_NP     = 4'd12;
	localparam logic [3:0] ST_NI     = 4'd13;
	localparam logic [3:0] ST_NT     = 4'd14;
	localparam logic [3:0] ST_OUT    = 4'd15;

	logic [3:0]           state_q;
	logic                 issued_q;
	logic [30:0]          cfg_q [NUM_REGS];
	logic signed [CW-1:0] start_q [4];
	logic signed [CW-1:0] goal_q [4];
	logic [30:0]          tmin_q, total_q, tl_q, tr_q;
	logic [SW-1:0]        step_q, progress_q, sl_q, sr_q;
	logic [WIDE_W-1:0]    sq_q;
	logic [WORD_W-1:0]    len_q, tv_q, s2_q, s3_q;
	logic [FRAC_BITS:0]   p_q;
	logic [1:0]           idx_q;
	logic                 cur_q;
	logic                 res_ok_q;
	logic [CW-1:0]        res_via_q [4];
	logic [30:0]          res_time_q;
	logic                 ov_q, o_ok_q;
	logic [CW-1:0]        o_via_q [4];
	logic [30:0]          o_time_q;
	logic                 out_load;

	alu_req_t          alu_req;
	alu_stat_t         alu_stat;
	logic [WIDE_W-1:0] alu_opa, alu_res;
	logic [WORD_W-1:0] alu_opb;

	qptg_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (alu_opa),
		.opb    (alu_opb),
		.stat   (alu_stat),
		.res    (alu_res)
	);

	// Per-axis differences and their magnitudes.
	logic [CW:0]       diff [4];
	logic [CW:0]       dmag [4];
	logic [WORD_W-1:0] mag [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			diff[i] = {goal_q[i][CW-1], goal_q[i]} - {start_q[i][CW-1], start_q[i]};
			dmag[i] = diff[i][CW] ? (~diff[i] + 1'b1) : diff[i];
			mag[i]  = WORD_W'(dmag[i]);
		end
	end

	logic [WORD_W-1:0] lenv, lenv15, vel, acc, tmax, sq_quo, p_raw, q_raw, via_w, base_w;
	logic [WORD_W+1:0] inner_p, inner_n;
	logic [WORD_W-1:0] inner;
	logic [30:0]       tclamp, tfin, tplan;
	logic [SW-1:0]     sclamp, splan;
	logic [SW:0]       prog_sum;
	logic [30:0]       vel_r, acc_r, stl_r;
	logic              next_done, next_snap;

	always_comb begin
		vel_r  = cur_q ? cfg_q[REG_ROT_VEL] : cfg_q[REG_LIN_VEL];
		acc_r  = cur_q ? cfg_q[REG_ROT_ACC] : cfg_q[REG_LIN_ACC];
		stl_r  = cur_q ? cfg_q[REG_ROT_STEP] : cfg_q[REG_LIN_STEP];
		vel    = (vel_r == '0) ? 64'd1 : WORD_W'(vel_r);
		acc    = (acc_r == '0) ? 64'd1 : WORD_W'(acc_r);
		lenv   = cur_q ? mag[3] : len_q;
		lenv15 = (lenv << 4) - lenv;

		tmax   = (tv_q > alu_res[WORD_W-1:0]) ? tv_q : alu_res[WORD_W-1:0];
		tclamp = (tmax > WORD_W'(TIME_MAX)) ? TIME_MAX : tmax[30:0];
		tfin   = (tmin_q > tclamp) ? tmin_q : tclamp;

		sq_quo = alu_res[WORD_W-1:0];
		if (sq_quo == '0)
			sclamp = SW'(1);
		else if (sq_quo > ONE_P1)
			sclamp = ONE_P1[SW-1:0];
		else
			sclamp = sq_quo[SW-1:0];

		tplan = (tl_q > tr_q) ? tl_q : tr_q;
		if (sl_q != '0 && sr_q != '0)
			splan = (sl_q < sr_q) ? sl_q : sr_q;
		else
			splan = sl_q | sr_q;

		prog_sum  = {1'b0, progress_q} + {1'b0, step_q};
		next_done = (step_q == '0) || (WORD_W'(progress_q) > ONE);
		next_snap = WORD_W'(prog_sum) >= ONE;

		// 10 - 15 s + 6 s^2 in Q form, floored at zero.
		inner_p = TEN_ONE + (66'(s2_q) << 2) + (66'(s2_q) << 1);
		inner_n = (66'(progress_q) << 4) - 66'(progress_q);
		inner   = (inner_p >= inner_n) ? WORD_W'(inner_p - inner_n) : '0;

		p_raw  = alu_res[FRAC_BITS +: WORD_W];
		q_raw  = alu_res[FRAC_BITS +: WORD_W];
		base_w = {{(WORD_W-CW){start_q[idx_q][CW-1]}}, start_q[idx_q]};
		via_w  = diff[idx_q][CW] ? base_w - q_raw : base_w + q_raw;
	end

	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = OP_MUL;
		alu_opa       = '0;
		alu_opb       = '0;
		unique case (state_q) inside
			ST_SQ: begin
				alu_opa = WIDE_W'(mag[idx_q]);
				alu_opb = mag[idx_q];
			end
			ST_SQRT_L: begin
				alu_req.op = OP_SQRT;
				alu_opa    = sq_q;
			end
			ST_TV: begin
				alu_req.op = OP_DIV;
				alu_opa    = WIDE_W'(lenv15) << FRAC_BITS;
				alu_opb    = vel << 3;
			end
			ST_AM: begin
				alu_opa = WIDE_W'(ACC_CONST);
				alu_opb = lenv;
			end
			ST_AD: begin
				alu_req.op = OP_DIV;
				alu_opa    = alu_res << ASH;
				alu_opb    = acc;
			end
			ST_AS: begin
				alu_req.op = OP_SQRT;
				alu_opa    = {{WORD_W{1'b0}}, alu_res[WORD_W-1:0]};
			end
			ST_SD: begin
				alu_req.op = OP_DIV;
				alu_opa    = WIDE_W'(WORD_W'(stl_r) << FRAC_BITS);
				alu_opb    = lenv;
			end
			ST_N2: begin
				alu_opa = WIDE_W'(progress_q);
				alu_opb = WORD_W'(progress_q);
			end
			ST_N3: begin
				alu_opa = WIDE_W'(s2_q);
				alu_opb = WORD_W'(progress_q);
			end
			ST_NP: begin
				alu_opa = WIDE_W'(s3_q);
				alu_opb = inner;
			end
			ST_NI: begin
				alu_opa = WIDE_W'(mag[idx_q]);
				alu_opb = WORD_W'(p_q);
			end
			ST_NT: begin
				alu_opa = WIDE_W'(total_q);
				alu_opb = WORD_W'(progress_q);
			end
			default: ;
		endcase
		unique case (state_q) inside
			ST_SQ, ST_SQRT_L, ST_TV, ST_AM, ST_AD, ST_AS, ST_SD,
			ST_N2, ST_N3, ST_NP, ST_NI, ST_NT:
				alu_req.start = !issued_q;
			default: alu_req.start = 1'b0;
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (!ov_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			issued_q   <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= ONE[30:0];
			for (int i = 0; i < 4; i++) begin
				start_q[i]   <= '0;
				goal_q[i]    <= '0;
				res_via_q[i] <= '0;
				o_via_q[i]   <= '0;
			end
			tmin_q     <= '0;
			total_q    <= '0;
			tl_q       <= '0;
			tr_q       <= '0;
			step_q     <= '0;
			progress_q <= '0;
			sl_q       <= '0;
			sr_q       <= '0;
			sq_q       <= '0;
			len_q      <= '0;
			tv_q       <= '0;
			s2_q       <= '0;
			s3_q       <= '0;
			p_q        <= '0;
			idx_q      <= '0;
			cur_q      <= 1'b0;
			res_ok_q   <= 1'b0;
			res_time_q <= '0;
			ov_q       <= 1'b0;
			o_ok_q     <= 1'b0;
			o_time_q   <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				unique case (paddr[4:2])
					REG_LIN_VEL, REG_LIN_ACC, REG_ROT_VEL, REG_ROT_ACC,
					REG_LIN_STEP, REG_ROT_STEP:
						cfg_q[paddr[4:2]] <= pwdata[30:0];
					default: ;
				endcase
			end
			if (out_load)
				ov_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				ov_q <= 1'b0;
			if (alu_req.start)
				issued_q <= 1'b1;
			if (alu_stat.done)
				issued_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.opcode == OPC_PLAN) begin
							start_q[0] <= in_ch.start_x;
							start_q[1] <= in_ch.start_y;
							start_q[2] <= in_ch.start_z;
							start_q[3] <= in_ch.start_k;
							goal_q[0]  <= in_ch.goal_x;
							goal_q[1]  <= in_ch.goal_y;
							goal_q[2]  <= in_ch.goal_z;
							goal_q[3]  <= in_ch.goal_k;
							tmin_q     <= in_ch.min_time;
							progress_q <= '0;
							step_q     <= '0;
							total_q    <= '0;
							sq_q       <= '0;
							idx_q      <= '0;
							cur_q      <= 1'b0;
							state_q    <= ST_SQ;
						end else if (next_done) begin
							res_ok_q   <= 1'b0;
							res_time_q <= '0;
							for (int i = 0; i < 4; i++) res_via_q[i] <= '0;
							state_q    <= ST_OUT;
						end else if (next_snap) begin
							// The last step lands exactly on the goal.
							res_ok_q   <= 1'b1;
							res_time_q <= total_q;
							for (int i = 0; i < 4; i++) res_via_q[i] <= goal_q[i];
							progress_q <= prog_sum[SW-1:0];
							state_q    <= ST_OUT;
						end else begin
							state_q <= ST_N2;
						end
					end
				end
				ST_SQ: begin
					if (alu_stat.done) begin
						sq_q  <= sq_q + alu_res;
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd2)
							state_q <= ST_SQRT_L;
					end
				end
				ST_SQRT_L: begin
					if (alu_stat.done) begin
						len_q   <= alu_res[WORD_W-1:0];
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (lenv == '0) begin
						if (cur_q) begin
							tr_q    <= '0;
							sr_q    <= '0;
							state_q <= ST_PEND;
						end else begin
							tl_q  <= '0;
							sl_q  <= '0;
							cur_q <= 1'b1;
						end
					end else begin
						state_q <= ST_TV;
					end
				end
				ST_TV: begin
					if (alu_stat.done) begin
						tv_q    <= alu_res[WORD_W-1:0];
						state_q <= ST_AM;
					end
				end
				ST_AM: if (alu_stat.done) state_q <= ST_AD;
				ST_AD: if (alu_stat.done) state_q <= ST_AS;
				ST_AS: begin
					if (alu_stat.done) begin
						if (cur_q) tr_q <= tfin;
						else tl_q <= tfin;
						state_q <= ST_SD;
					end
				end
				ST_SD: begin
					if (alu_stat.done) begin
						if (cur_q) begin
							sr_q    <= sclamp;
							state_q <= ST_PEND;
						end else begin
							sl_q    <= sclamp;
							cur_q   <= 1'b1;
							state_q <= ST_LEN;
						end
					end
				end
				ST_PEND: begin
					res_time_q <= '0;
					for (int i = 0; i < 4; i++) res_via_q[i] <= '0;
					if (tplan == '0) begin
						res_ok_q <= 1'b0;
					end else begin
						res_ok_q <= 1'b1;
						total_q  <= tplan;
						step_q   <= splan;
					end
					state_q <= ST_OUT;
				end
				ST_N2: begin
					if (alu_stat.done) begin
						s2_q    <= alu_res[FRAC_BITS +: WORD_W];
						state_q <= ST_N3;
					end
				end
				ST_N3: begin
					if (alu_stat.done) begin
						s3_q    <= alu_res[FRAC_BITS +: WORD_W];
						state_q <= ST_NP;
					end
				end
				ST_NP: begin
					if (alu_stat.done) begin
						p_q     <= (p_raw > ONE) ? ONE[FRAC_BITS:0] : p_raw[FRAC_BITS:0];
						idx_q   <= '0;
						state_q <= ST_NI;
					end
				end
				ST_NI: begin
					if (alu_stat.done) begin
						res_via_q[idx_q] <= via_w[CW-1:0];
						idx_q            <= idx_q + 2'd1;
						if (idx_q == 2'd3)
							state_q <= ST_NT;
					end
				end
				ST_NT: begin
					if (alu_stat.done) begin
						res_time_q <= alu_res[FRAC_BITS +: 31];
						res_ok_q   <= 1'b1;
						progress_q <= prog_sum[SW-1:0];
						state_q    <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						o_ok_q   <= res_ok_q;
						o_time_q <= res_time_q;
						for (int i = 0; i < 4; i++) o_via_q[i] <= res_via_q[i];
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign out_ch.valid    = ov_q;
	assign out_ch.ok_flag  = o_ok_q;
	assign out_ch.via_x    = o_via_q[0];
	assign out_ch.via_y    = o_via_q[1];
	assign out_ch.via_z    = o_via_q[2];
	assign out_ch.via_k    = o_via_q[3];
	assign out_ch.via_time = o_time_q;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[4:2])
			REG_LIN_VEL:  prdata = {1'b0, cfg_q[REG_LIN_VEL]};
			REG_LIN_ACC:  prdata = {1'b0, cfg_q[REG_LIN_ACC]};
			REG_ROT_VEL:  prdata = {1'b0, cfg_q[REG_ROT_VEL]};
			REG_ROT_ACC:  prdata = {1'b0, cfg_q[REG_ROT_ACC]};
			REG_LIN_STEP: prdata = {1'b0, cfg_q[REG_LIN_STEP]};
			REG_ROT_STEP: prdata = {1'b0, cfg_q[REG_ROT_STEP]};
			default:      prdata = '0;
		endcase
	end

`ifndef ASSERT_OFF
	a_plan_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == '0) == (total_q == '0))
		else $error("step and travel time disagree on whether a trajectory exists");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		WORD_W'(step_q) <= ONE_P1)
		else $error("step exceeds one plus one LSB");
	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		WORD_W'(progress_q) <= (ONE << 1) + 64'd1)
		else $error("progress out of range");
	a_alu_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !alu_stat.busy && !issued_q)
		else $error("command accepted while arithmetic is still in flight");
`endif

endmodule

`default_nettype wire

[hdl/qptg_alu.sv]
// Shared bit-serial arithmetic unit: multiply, saturating divide, square root.
// One quotient or root bit, or one multiplier bit, per cycle; depends on qptg_pkg.
`default_nettype none

module qptg_alu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  qptg_pkg::alu_req_t                  req,
	input  logic [qptg_pkg::WIDE_W-1:0]         opa,
	input  logic [qptg_pkg::WORD_W-1:0]         opb,
	output qptg_pkg::alu_stat_t                 stat,
	output logic [qptg_pkg::WIDE_W-1:0]         res
);
	import qptg_pkg::*;

	localparam int REM_W = WORD_W + 4;

	logic              busy_q, done_q, sat_q;
	logic [1:0]        op_q;
	logic [7:0]        cnt_q;
	logic [WIDE_W-1:0] acc_q, sh_q;
	logic [WORD_W-1:0] b_q, q_q;
	logic [REM_W-1:0]  rem_q;

	logic [WIDE_W-1:0] mul_acc;
	logic [REM_W-1:0]  div_r, sq_r, sq_t;
	logic              div_ge, sq_ge;

	assign mul_acc = acc_q + (b_q[0] ? sh_q : '0);
	assign div_r   = {rem_q[REM_W-2:0], sh_q[WIDE_W-1]};
	assign div_ge  = div_r >= REM_W'(b_q);
	assign sq_r    = {rem_q[REM_W-3:0], sh_q[WIDE_W-1 -: 2]};
	assign sq_t    = {2'b00, q_q, 2'b01};
	assign sq_ge   = sq_r >= sq_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? 8'(WIDE_W) : 8'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			sh_q  <= opa;
			b_q   <= opb;
			rem_q <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			unique case (op_q)
				OP_DIV: begin
					sh_q  <= sh_q << 1;
					rem_q <= div_ge ? div_r - REM_W'(b_q) : div_r;
					q_q   <= {q_q[WORD_W-2:0], div_ge};
					// A quotient bit in the upper half means the result overflows.
					if (div_ge && cnt_q > 8'(WORD_W))
						sat_q <= 1'b1;
				end
				OP_SQRT: begin
					sh_q  <= sh_q << 2;
					rem_q <= sq_ge ? sq_r - sq_t : sq_r;
					q_q   <= {q_q[WORD_W-2:0], sq_ge};
				end
				default: begin
					acc_q <= mul_acc;
					sh_q  <= sh_q << 1;
					b_q   <= b_q >> 1;
				end
			endcase
		end
	end

	always_comb begin
		unique case (op_q)
			OP_DIV:  res = {{WORD_W{1'b0}}, (sat_q ? {WORD_W{1'b1}} : q_q)};
			OP_SQRT: res = {{WORD_W{1'b0}}, q_q};
			default: res = acc_q;
		endcase
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("arithmetic unit started while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("completion flag held for more than one cycle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("completion without a preceding operation");
`endif

endmodule

`default_nettype wire

[test/qptg_checker.sv]
// Checker for the quintic point-to-point trajectory generator: predicts every via point
// transaction from the command and configuration transactions and compares field by field.
// Depends on qptg_pkg and the channel interfaces in qptg_if.
`timescale 1ns / 100ps

module qptg_checker (
	input  logic        clk,
	input  logic        arst_n,
	qptg_in_if          in_mon,
	qptg_out_if         out_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import qptg_pkg::*;

	localparam logic [63:0] ONE = 64'd1 << 16;

	typedef struct {
		logic        ok;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] k;
		logic [30:0] t;
	} via_t;

	longint      start_p [4];
	longint      goal_p [4];
	logic [63:0] trip_t;
	logic [63:0] step;
	logic [63:0] progress;
	logic [63:0] limits [NUM_REGS];
	via_t        via_q [$];

	initial fail_count = 0;

	function automatic logic [63:0] div_sat(input logic [127:0] n, input logic [63:0] d);
		logic [127:0] q;
		q = n / {64'd0, d};
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic logic [63:0] isqrt(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] at_least_one(input logic [63:0] v);
		return (v == 0) ? 64'd1 : v;
	endfunction

	function automatic logic [63:0] magnitude(input longint d);
		return (d < 0) ? 64'd0 - 64'(d) : 64'(d);
	endfunction

	// Larger of the velocity-bound and acceleration-bound times, saturated, then min_time.
	function automatic logic [63:0] travel_of(input logic [63:0] len, input logic [63:0] vel,
			input logic [63:0] acc, input logic [63:0] tmin);
		logic [63:0] l15;
		logic [63:0] tv;
		logic [63:0] ta;
		logic [63:0] t;
		l15 = 64'd15 * len;
		tv = div_sat({64'd0, l15} << 16, 64'd8 * at_least_one(vel));
		ta = isqrt({64'd0, div_sat(({64'd0, ACC_CONST} * {64'd0, len}) << 16,
			at_least_one(acc))});
		t = (tv > ta) ? tv : ta;
		if (t > 64'(TIME_MAX))
			t = 64'(TIME_MAX);
		return (tmin > t) ? tmin : t;
	endfunction

	function automatic logic [63:0] step_of(input logic [63:0] step_len, input logic [63:0] len);
		logic [63:0] q;
		q = (step_len * ONE) / len;
		if (q == 0)
			q = 1;
		if (q > ONE + 1)
			q = ONE + 1;
		return q;
	endfunction

	function automatic logic [63:0] quintic(input logic [63:0] s);
		logic [63:0]  s2;
		logic [63:0]  s3;
		longint       inner;
		logic [127:0] prod;
		logic [63:0]  p;
		s2 = (s * s) >> 16;
		s3 = (s2 * s) >> 16;
		inner = COEF_A * longint'(ONE) - COEF_B * longint'(s) + COEF_C * longint'(s2);
		if (inner < 0)
			inner = 0;
		prod = ({64'd0, s3} * {64'd0, 64'(inner)}) >> 16;
		p = prod[63:0];
		return (p > ONE) ? ONE : p;
	endfunction

	function automatic logic [31:0] blend(input longint a, input longint b, input logic [63:0] p);
		longint       d;
		logic [127:0] prod;
		d = b - a;
		prod = ({64'd0, magnitude(d)} * {64'd0, p}) >> 16;
		return (d < 0) ? 32'(a - longint'(prod[63:0])) : 32'(a + longint'(prod[63:0]));
	endfunction

	function automatic via_t plan_trajectory(input longint s [4], input longint g [4],
			input logic [63:0] tmin);
		via_t         v;
		logic [127:0] sq;
		logic [63:0]  m;
		logic [63:0]  len;
		logic [63:0]  rot;
		logic [63:0]  tl;
		logic [63:0]  tr;
		logic [63:0]  sl;
		logic [63:0]  sr;
		logic [63:0]  t;
		v = '{ok: 1'b0, x: '0, y: '0, z: '0, k: '0, t: '0};
		start_p = s;
		goal_p = g;
		progress = 0;
		step = 0;
		trip_t = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m = magnitude(g[i] - s[i]);
			sq = sq + {64'd0, m} * {64'd0, m};
		end
		len = isqrt(sq);
		rot = magnitude(g[3] - s[3]);
		tl = 0;
		tr = 0;
		sl = 0;
		sr = 0;
		if (len != 0) begin
			tl = travel_of(len, limits[REG_LIN_VEL], limits[REG_LIN_ACC], tmin);
			sl = step_of(limits[REG_LIN_STEP], len);
		end
		if (rot != 0) begin
			tr = travel_of(rot, limits[REG_ROT_VEL], limits[REG_ROT_ACC], tmin);
			sr = step_of(limits[REG_ROT_STEP], rot);
		end
		t = (tl > tr) ? tl : tr;
		if (t == 0)
			return v;
		trip_t = t;
		if (sl != 0 && sr != 0)
			step = (sl < sr) ? sl : sr;
		else
			step = sl | sr;
		v.ok = 1'b1;
		return v;
	endfunction

	function automatic via_t next_via();
		via_t        v;
		logic [63:0] p;
		logic [31:0] c [4];
		v = '{ok: 1'b0, x: '0, y: '0, z: '0, k: '0, t: '0};
		if (step == 0 || progress > ONE)
			return v;
		if (progress + step < ONE) begin
			p = quintic(progress);
			v.t = 31'((trip_t * progress) >> 16);
			for (int i = 0; i < 4; i++)
				c[i] = blend(start_p[i], goal_p[i], p);
		end else begin
			// Last step lands exactly on the goal.
			v.t = 31'(trip_t);
			for (int i = 0; i < 4; i++)
				c[i] = 32'(goal_p[i]);
		end
		progress = progress + step;
		v.ok = 1'b1;
		v.x = c[0];
		v.y = c[1];
		v.z = c[2];
		v.k = c[3];
		return v;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t: via point %s is %h, expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		longint s [4];
		longint g [4];
		via_t   v;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				start_p[i] = 0;
				goal_p[i] = 0;
			end
			for (int i = 0; i < NUM_REGS; i++)
				limits[i] = ONE;
			trip_t = 0;
			step = 0;
			progress = 0;
			via_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[4:2] < NUM_REGS)
				limits[paddr[4:2]] = {33'd0, pwdata[30:0]};
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.opcode == OPC_PLAN) begin
					s = '{in_mon.start_x, in_mon.start_y, in_mon.start_z, in_mon.start_k};
					g = '{in_mon.goal_x, in_mon.goal_y, in_mon.goal_z, in_mon.goal_k};
					via_q.push_back(plan_trajectory(s, g, {33'd0, in_mon.min_time}));
				end else begin
					via_q.push_back(next_via());
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				if (via_q.size() == 0) begin
					$display("%0t: via point transaction with nothing expected", $realtime);
					fail_count++;
				end else begin
					v = via_q.pop_front();
					if (out_mon.ok_flag !== v.ok)
						report("ok_flag", {31'd0, out_mon.ok_flag}, {31'd0, v.ok});
					if (out_mon.via_x !== v.x)
						report("via_x", out_mon.via_x, v.x);
					if (out_mon.via_y !== v.y)
						report("via_y", out_mon.via_y, v.y);
					if (out_mon.via_z !== v.z)
						report("via_z", out_mon.via_z, v.z);
					if (out_mon.via_k !== v.k)
						report("via_k", out_mon.via_k, v.k);
					if (out_mon.via_time !== v.t)
						report("via_time", {1'b0, out_mon.via_time}, {1'b0, v.t});
				end
			end
			pending <= via_q.size();
		end
	end

endmodule

[test/tb_quintic_ptp_trajectory_generator_core.sv]
// Testbench top for the quintic point-to-point trajectory generator: clock, reset, register
// writes, command stimulus and handshake idling. Checking is done by qptg_checker.
// Depends on qptg_pkg, qptg_if, the block itself and qptg_checker.
`timescale 1ns / 100ps

module tb_quintic_ptp_trajectory_generator_core;
	import qptg_pkg::*;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic        opc;
		logic [31:0] s [4];
		logic [31:0] g [4];
		logic [30:0] tmin;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          tx_idle = 20;
	int          rx_idle = 84;
	int          sent = 0;
	logic        hold_go = 1'b0;
	logic        hold_used = 1'b0;
	int          hold_left = 0;

	qptg_in_if  in_ch ();
	qptg_out_if out_ch ();

	quintic_ptp_trajectory_generator_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	qptg_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	// Receiver: random idling, plus one long hold-off that lets the block back up.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			out_ch.ready <= 1'b0;
			hold_left <= 4000;
			hold_used <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	initial begin
		#(100_000_000);
		$display("quintic_ptp_trajectory_generator_core: mismatch");
		$finish;
	end

	task automatic send(input cmd_t c);
		int gap;
		if ($urandom_range(99) < tx_idle) begin
			gap = $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= c.opc;
		in_ch.start_x <= c.s[0];
		in_ch.start_y <= c.s[1];
		in_ch.start_z <= c.s[2];
		in_ch.start_k <= c.s[3];
		in_ch.goal_x <= c.g[0];
		in_ch.goal_y <= c.g[1];
		in_ch.goal_z <= c.g[2];
		in_ch.goal_k <= c.g[3];
		in_ch.min_time <= c.tmin;
		@(negedge clk);
		while (!in_ch.ready)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cmd_t next_cmd();
		cmd_t c;
		c.opc = OPC_NEXT;
		for (int i = 0; i < 4; i++) begin
			c.s[i] = $urandom;
			c.g[i] = $urandom;
		end
		c.tmin = 31'($urandom);
		return c;
	endfunction

	function automatic cmd_t plan_cmd(input logic [31:0] s0, s1, s2, s3, g0, g1, g2, g3,
			input logic [30:0] tmin);
		cmd_t c;
		c.opc = OPC_PLAN;
		c.s = '{s0, s1, s2, s3};
		c.g = '{g0, g1, g2, g3};
		c.tmin = tmin;
		return c;
	endfunction

	// Random start with a goal a modest distance away, so that trajectories can finish.
	function automatic cmd_t short_plan();
		cmd_t c;
		int   d;
		int   sh;
		int   shape;
		c.opc = OPC_PLAN;
		shape = $urandom_range(9);
		for (int i = 0; i < 4; i++) begin
			sh = $urandom_range(8, 20);
			d = int'($urandom_range(0, 1 << sh));
			if ($urandom_range(1))
				d = -d;
			if ((shape == 0 && i < 3) || (shape == 1 && i == 3) || $urandom_range(7) == 0)
				d = 0;
			c.s[i] = $urandom;
			c.g[i] = c.s[i] + 32'(d);
		end
		case ($urandom_range(9)) inside
			[0:5]: c.tmin = '0;
			[6:7]: c.tmin = 31'($urandom_range(0, 1 << 20));
			8: c.tmin = 31'($urandom);
			default: c.tmin = TIME_MAX;
		endcase
		return c;
	endfunction

	function automatic cmd_t wild_plan();
		cmd_t c;
		c = next_cmd();
		c.opc = OPC_PLAN;
		return c;
	endfunction

	task automatic random_traffic(input int count);
		int   stop;
		int   n;
		cmd_t c;
		stop = sent + count;
		while (sent < stop) begin
			case ($urandom_range(99)) inside
				[0:7]: send(next_cmd());
				[8:13]: begin
					send(wild_plan());
					repeat ($urandom_range(1, 3)) send(next_cmd());
				end
				default: begin
					c = short_plan();
					send(c);
					n = $urandom_range(1, 30);
					for (int i = 0; i < n && sent < stop; i++)
						send(next_cmd());
				end
			endcase
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OPC_PLAN;
		in_ch.start_x = '0;
		in_ch.start_y = '0;
		in_ch.start_z = '0;
		in_ch.start_k = '0;
		in_ch.goal_x = '0;
		in_ch.goal_y = '0;
		in_ch.goal_z = '0;
		in_ch.goal_k = '0;
		in_ch.min_time = '0;
		out_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the limits at their reset values.
		send(next_cmd());
		send(plan_cmd('0, '0, '0, '0, '0, '0, '0, '0, TIME_MAX));
		send(next_cmd());
		send(plan_cmd(32'h0001_0000, '0, '0, '0, 32'h0001_0000, '0, '0, 32'h0003_0000, '0));
		repeat (5) send(next_cmd());
		send(plan_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, TIME_MAX));
		repeat (2) send(next_cmd());
		send(plan_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
		send(next_cmd());
		send(plan_cmd('0, '0, '0, '0, 32'h0002_0000, 32'hFFFF_0000, '0, '0, 31'h0005_0000));
		repeat (4) send(next_cmd());
		send(plan_cmd('0, '0, '0, '0, 32'h0000_0001, '0, '0, '0, TIME_MAX));
		send(next_cmd());
		drain();

		// Fast motion, slow acceleration, coarse linear steps; bit 31 must be ignored.
		write_reg(REG_LIN_VEL, 32'h7FFF_FFFF);
		write_reg(REG_LIN_ACC, 32'h8000_0001);
		write_reg(REG_ROT_VEL, 32'h0000_0000);
		write_reg(REG_ROT_ACC, 32'hFFFF_FFFF);
		write_reg(REG_LIN_STEP, 32'h7FFF_FFFF);
		write_reg(REG_ROT_STEP, 32'h0000_8000);
		write_reg(REG_SPARE_A, 32'h0000_0001);
		write_reg(REG_SPARE_B, 32'h0000_0000);
		@(posedge clk);
		random_traffic(200);
		drain();

		tx_idle = 84;
		rx_idle = 20;
		write_reg(REG_LIN_VEL, 32'h0000_0001);
		write_reg(REG_LIN_ACC, 32'h7FFF_FFFF);
		write_reg(REG_ROT_VEL, 32'h7FFF_FFFF);
		write_reg(REG_ROT_ACC, 32'h0000_0000);
		write_reg(REG_LIN_STEP, 32'h0000_4000);
		write_reg(REG_ROT_STEP, 32'h7FFF_FFFF);
		@(posedge clk);
		random_traffic(200);
		drain();

		tx_idle = 0;
		rx_idle = 0;
		write_reg(REG_LIN_VEL, $urandom_range(1 << 12, 1 << 24));
		write_reg(REG_LIN_ACC, $urandom_range(1 << 12, 1 << 24));
		write_reg(REG_ROT_VEL, $urandom_range(1 << 12, 1 << 24));
		write_reg(REG_ROT_ACC, $urandom_range(1 << 12, 1 << 24));
		write_reg(REG_LIN_STEP, $urandom_range(1 << 15, 1 << 18));
		write_reg(REG_ROT_STEP, $urandom_range(1 << 15, 1 << 18));
		@(posedge clk);
		random_traffic(100);
		// The receiver now holds off for a long stretch while commands keep coming.
		hold_go <= 1'b1;
		random_traffic(130);
		drain();

		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("quintic_ptp_trajectory_generator_core: match");
		else
			$display("quintic_ptp_trajectory_generator_core: mismatch");
		$finish;
	end

endmodule
